// ===== hdl/sobg_pkg.sv =====
// ----------------------------------------------------------------------------
// sobg_pkg
// Shared constants, types and helpers of the streaming 3x3 gradient block.
// ----------------------------------------------------------------------------
package sobg_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // register field widths
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // payload widths
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 11;
  localparam int SUM_W  = PIX_W + 2;
  localparam int LS_W   = 2 * PIX_W;

  // position counters and clamped sizes
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  // reset values of the size registers
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATOR_MODE = 2'd2;

  // item kinds and operator modes
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_DRAIN   = 1'b1;
  localparam logic MODE_SOBEL   = 1'b0;
  localparam logic MODE_CENTRAL = 1'b1;

  // 3x3 window, index [row][column], row 0 oldest, column 0 leftmost
  typedef logic [2:0][2:0][PIX_W-1:0] sobg_win_t;

  // per-item info carried from the position stage to the window stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             drain;
    logic             emit;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             frame_end;
  } sobg_tag_t;

  // control from the register side
  typedef struct packed {
    logic restart;
    logic mode;
  } sobg_ctl_t;

  function automatic logic [EW_W-1:0] clamp_width(input logic [WID_W-1:0] v);
    int unsigned t;
    t = 32'(v);
    if (t < 32'd2) t = 32'd2;
    else if (t > 32'(MAX_WIDTH)) t = 32'(MAX_WIDTH);
    return EW_W'(t);
  endfunction

  function automatic logic [EH_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
    int unsigned t;
    t = 32'(v);
    if (t < 32'd2) t = 32'd2;
    else if (t > 32'(MAX_HEIGHT)) t = 32'(MAX_HEIGHT);
    return EH_W'(t);
  endfunction

endpackage

// ===== hdl/sobg_pix_if.sv =====
// ----------------------------------------------------------------------------
// sobg_pix_if
// Pixel stream channel: valid, ready, item kind and gray value.
// ----------------------------------------------------------------------------
interface sobg_pix_if;
  import sobg_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel;

  modport source(output valid, kind, pixel, input ready);
  modport sink(input valid, kind, pixel, output ready);
endinterface

// ===== hdl/sobg_grad_if.sv =====
// ----------------------------------------------------------------------------
// sobg_grad_if
// Gradient result channel: valid, ready, both gradients and frame end flag.
// ----------------------------------------------------------------------------
interface sobg_grad_if;
  import sobg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     frame_end;

  modport source(output valid, grad_x, grad_y, frame_end, input ready);
  modport sink(input valid, grad_x, grad_y, frame_end, output ready);
endinterface

// ===== hdl/sobg_line_store.sv =====
// ----------------------------------------------------------------------------
// sobg_line_store
// Two row stores packed in one word per column, one read and one write port.
// ----------------------------------------------------------------------------
module sobg_line_store (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [sobg_pkg::COL_W-1:0]     rd_addr,
  output logic [sobg_pkg::LS_W-1:0]      rd_data,
  input  logic                           wr_en,
  input  logic [sobg_pkg::COL_W-1:0]     wr_addr,
  input  logic [sobg_pkg::LS_W-1:0]      wr_data
);
  import sobg_pkg::*;

  // upper byte: two rows up, lower byte: one row up
  logic [LS_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== hdl/sobg_position.sv =====
// ----------------------------------------------------------------------------
// sobg_position
// Size and mode registers, raster position and per-item border flags.
// ----------------------------------------------------------------------------
module sobg_position (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sobg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic                             kind,
  input  logic [sobg_pkg::PIX_W-1:0]       pixel,
  output logic                             issue,
  output sobg_pkg::sobg_tag_t              tag,
  output sobg_pkg::sobg_ctl_t              ctl
);
  import sobg_pkg::*;

  logic [EW_W-1:0]  width;
  logic [EH_W-1:0]  height;
  logic             mode;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [ROW_W-1:0] h_row;
  logic             past_end;
  logic             drain;
  logic             first_col;
  logic             last_col;
  logic             restart;

  assign h_row     = ROW_W'(height);
  assign past_end  = row >= h_row;
  assign drain     = (kind == KIND_DRAIN) || past_end;
  assign first_col = col == '0;
  assign last_col  = (EW_W'(col) + EW_W'(1)) >= width;
  // a drain before the frame is complete does nothing
  assign issue     = accept && !((kind == KIND_DRAIN) && !past_end);
  assign restart   = cfg_write &&
                     ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    tag.col       = col;
    tag.pix       = drain ? '0 : pixel;
    tag.drain     = drain;
    tag.emit      = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && !first_col);
    // column 0 closes the previous row: output row is two back
    tag.top_ok    = first_col ? (row >= ROW_W'(3)) : (row >= ROW_W'(2));
    tag.bot_ok    = first_col ? (row <= h_row) : (row < h_row);
    tag.left_ok   = first_col || (col >= COL_W'(2));
    tag.right_ok  = !first_col;
    tag.frame_end = row == (h_row + ROW_W'(1));
    ctl.restart   = restart;
    ctl.mode      = mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= clamp_width(WID_W'(RESET_WIDTH));
      height <= clamp_height(HGT_W'(RESET_HEIGHT));
      mode   <= MODE_SOBEL;
      col    <= '0;
      row    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:   width  <= clamp_width(cfg_data[WID_W-1:0]);
          REG_FRAME_HEIGHT:  height <= clamp_height(cfg_data[HGT_W-1:0]);
          REG_OPERATOR_MODE: mode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (restart) begin
        col <= '0;
        row <= '0;
      end else if (issue) begin
        if (tag.frame_end) begin
          col <= '0;
          row <= '0;
        end else if (last_col) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end
endmodule

// ===== hdl/sobg_gradient.sv =====
// ----------------------------------------------------------------------------
// sobg_gradient
// Line store write-back, window shift, border rule, gradients, output word.
// ----------------------------------------------------------------------------
module sobg_gradient (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  sobg_pkg::sobg_tag_t          tag_in,
  input  sobg_pkg::sobg_ctl_t          ctl,
  input  logic [sobg_pkg::LS_W-1:0]    rd_data,
  output logic                         s1_ready,
  output logic                         wr_en,
  output logic [sobg_pkg::COL_W-1:0]   wr_addr,
  output logic [sobg_pkg::LS_W-1:0]    wr_data,
  sobg_grad_if.source                  gradients
);
  import sobg_pkg::*;

  logic      s1_valid;
  sobg_tag_t s1_tag;
  sobg_win_t win;
  sobg_win_t win_next;

  logic             out_free;
  logic             s1_adv;
  logic [PIX_W-1:0] up1;
  logic [PIX_W-1:0] up2;

  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;

  assign out_free = !gradients.valid || gradients.ready;
  assign s1_adv   = s1_valid && (!s1_tag.emit || out_free);
  assign s1_ready = !s1_valid || s1_adv;

  assign up2 = rd_data[LS_W-1:PIX_W];
  assign up1 = rd_data[PIX_W-1:0];

  assign wr_en   = s1_adv && !s1_tag.drain;
  assign wr_addr = s1_tag.col;
  assign wr_data = {up1, s1_tag.pix};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = up2;
    win_next[1][2] = up1;
    win_next[2][2] = s1_tag.pix;
  end

  always_comb begin
    sobg_win_t        p;
    logic [SUM_W-1:0] s_right;
    logic [SUM_W-1:0] s_left;
    logic [SUM_W-1:0] s_bot;
    logic [SUM_W-1:0] s_top;
    logic [PIX_W-1:0] c_right;
    logic [PIX_W-1:0] c_left;
    logic [PIX_W-1:0] c_bot;
    logic [PIX_W-1:0] c_top;
    p = win_next;
    // replicated border: rows first, then columns
    for (int c = 0; c < 3; c++) begin
      if (!s1_tag.top_ok) p[0][c] = p[1][c];
      if (!s1_tag.bot_ok) p[2][c] = p[1][c];
    end
    for (int r = 0; r < 3; r++) begin
      if (!s1_tag.left_ok)  p[r][0] = p[r][1];
      if (!s1_tag.right_ok) p[r][2] = p[r][1];
    end
    s_right = SUM_W'(p[0][2]) + (SUM_W'(p[1][2]) << 1) + SUM_W'(p[2][2]);
    s_left  = SUM_W'(p[0][0]) + (SUM_W'(p[1][0]) << 1) + SUM_W'(p[2][0]);
    s_bot   = SUM_W'(p[2][0]) + (SUM_W'(p[2][1]) << 1) + SUM_W'(p[2][2]);
    s_top   = SUM_W'(p[0][0]) + (SUM_W'(p[0][1]) << 1) + SUM_W'(p[0][2]);
    // zero border for the central difference
    c_right = s1_tag.right_ok ? win_next[1][2] : '0;
    c_left  = s1_tag.left_ok  ? win_next[1][0] : '0;
    c_bot   = s1_tag.bot_ok   ? win_next[2][1] : '0;
    c_top   = s1_tag.top_ok   ? win_next[0][1] : '0;
    if (ctl.mode == MODE_SOBEL) begin
      gx = $signed(GRAD_W'(s_right)) - $signed(GRAD_W'(s_left));
      gy = $signed(GRAD_W'(s_bot)) - $signed(GRAD_W'(s_top));
    end else begin
      gx = $signed(GRAD_W'(c_right)) - $signed(GRAD_W'(c_left));
      gy = $signed(GRAD_W'(c_bot)) - $signed(GRAD_W'(c_top));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      gradients.valid <= 1'b0;
      win             <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= load;
      end
      if (s1_adv && s1_tag.emit) begin
        gradients.valid <= 1'b1;
      end else if (gradients.ready) begin
        gradients.valid <= 1'b0;
      end
      if (ctl.restart) begin
        win <= '0;
      end else if (s1_adv) begin
        win <= s1_tag.frame_end ? '0 : win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && load) begin
      s1_tag <= tag_in;
    end
    if (s1_adv && s1_tag.emit) begin
      gradients.grad_x    <= gx;
      gradients.grad_y    <= gy;
      gradients.frame_end <= s1_tag.frame_end;
    end
  end

  // a stalled item keeps its info
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_tag))
    else $error("window stage item changed while stalled");

  // write-back only for a live pixel item
  a_wr_live: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid && !s1_tag.drain)
    else $error("line store written without a pixel item");

  // the last result of a frame always comes from a tail item
  a_end_tail: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_tag.frame_end |-> s1_tag.emit && s1_tag.drain && !s1_tag.right_ok)
    else $error("frame end on a non-tail item");

  // a finished result shows up in the output word
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_tag.emit |=> gradients.valid)
    else $error("result lost between window stage and output");
endmodule

// ===== hdl/image_gradient_sobel_or_central.sv =====
// ----------------------------------------------------------------------------
// image_gradient_sobel_or_central
// Streaming 3x3 gradient over raster pixels, Sobel or central difference.
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless the output stalls, set by the single
//   line store read-modify-write (read at accept, write back as the item leaves)
// output: a result is registered as the word completing its window moves on,
//   which is width+1 words after its own pixel; drain words flush the tail
// reset: sizes to 640x480, Sobel mode, position and window cleared; the line
//   store holds no reset and gets no clearing pass
module image_gradient_sobel_or_central (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sobg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobg_pkg::CFG_DATA_W-1:0]  cfg_data,
  sobg_pix_if.sink                         pixels,
  sobg_grad_if.source                      gradients
);
  import sobg_pkg::*;

  logic             accept;
  logic             issue;
  sobg_tag_t        tag;
  sobg_ctl_t        ctl;
  logic             s1_ready;
  logic [LS_W-1:0]  rd_data;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [LS_W-1:0]  wr_data;

  // the window stage frees up whenever its item moves on
  assign pixels.ready = s1_ready;
  assign accept       = pixels.valid && pixels.ready;

  // position counters, border flags and the register file
  sobg_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (pixels.kind),
    .pixel     (pixels.pixel),
    .issue     (issue),
    .tag       (tag),
    .ctl       (ctl)
  );

  // row stores: read at the column of the accepted word; consecutive words
  // never share a column, so no forwarding is needed
  sobg_line_store u_line_store (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (tag.col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // window shift, border handling, gradient math and the output word
  sobg_gradient u_gradient (
    .clk       (clk),
    .rst       (rst),
    .load      (issue),
    .tag_in    (tag),
    .ctl       (ctl),
    .rd_data   (rd_data),
    .s1_ready  (s1_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .gradients (gradients)
  );
endmodule
